>>> rtl/core/sdinit_pkg.sv
// shared types and constants for the sd card init sequencer
package sdinit_pkg;

    // sequencer phases, one-hot
    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_CMD0   = 14'b00000000000010,
        PH_CMD8   = 14'b00000000000100,
        PH_APP    = 14'b00000000001000,
        PH_OPCOND = 14'b00000000010000,
        PH_CID    = 14'b00000000100000,
        PH_RCA    = 14'b00000001000000,
        PH_CSD    = 14'b00000010000000,
        PH_SELECT = 14'b00000100000000,
        PH_APP2   = 14'b00001000000000,
        PH_WIDTH  = 14'b00010000000000,
        PH_SWITCH = 14'b00100000000000,
        PH_DONE   = 14'b01000000000000,
        PH_FAILED = 14'b10000000000000
    } t_phase;

    // input item kinds
    localparam logic ITEM_START   = 1'b0;
    localparam logic ITEM_OUTCOME = 1'b1;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
    localparam logic [5:0] CMD_SWITCH      = 6'd6;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] ACMD_OP_COND    = 6'd41;
    localparam logic [5:0] CMD_APP         = 6'd55;

    // expected response kinds
    localparam logic [2:0] RSP_NONE = 3'd0;
    localparam logic [2:0] RSP_R1   = 3'd1;
    localparam logic [2:0] RSP_R1B  = 3'd2;
    localparam logic [2:0] RSP_R2   = 3'd3;
    localparam logic [2:0] RSP_R3   = 3'd4;

    // arguments and response constants
    localparam logic [31:0] IF_COND_ARG    = 32'h0000_01AA;
    localparam logic [31:0] SWITCH_HS_ARG  = 32'h80FF_FFF1;
    localparam logic [31:0] BUS_WIDTH4_ARG = 32'h0000_0002;
    localparam logic [31:0] HCS_ARG_BIT    = 32'h4000_0000;
    localparam logic [3:0]  SWITCH_HS_OK   = 4'd1;
    localparam logic [23:0] VOLTAGE_RESET  = 24'h30_0000;

    // kept-result widths
    localparam int CAP_W = 33;
    localparam int RCA_W = 16;

endpackage

>>> rtl/core/sdinit_capacity.sv
// card capacity in 512-byte blocks from a 128-bit csd response
module sdinit_capacity
    import sdinit_pkg::*;
(
    input  logic [127:0]       i_csd,
    output logic [CAP_W-1:0]   o_blocks
);

    logic [7:0]  byte0, byte5, byte6, byte7, byte8, byte9, byte10;
    logic [11:0] c_size_v1;
    logic [12:0] c_plus_v1;
    logic [2:0]  c_mult;
    logic [3:0]  rd_bl_len;
    logic [4:0]  shift_v1;
    logic [37:0] bytes_v1;
    logic [21:0] c_size_v2;
    logic [22:0] c_plus_v2;

    // csd byte i sits at bits 119-8i down to 112-8i
    assign byte0  = i_csd[119:112];
    assign byte5  = i_csd[79:72];
    assign byte6  = i_csd[71:64];
    assign byte7  = i_csd[63:56];
    assign byte8  = i_csd[55:48];
    assign byte9  = i_csd[47:40];
    assign byte10 = i_csd[39:32];

    // v1 layout: (c_size+1) << (mult+2+read_bl_len) >> 9
    assign c_size_v1 = {byte6[1:0], byte7, byte8[7:6]};
    assign c_plus_v1 = {1'b0, c_size_v1} + 13'd1;
    assign c_mult    = {byte9[1:0], byte10[7]};
    assign rd_bl_len = byte5[3:0];
    assign shift_v1  = {2'b00, c_mult} + {1'b0, rd_bl_len} + 5'd2;
    assign bytes_v1  = {25'd0, c_plus_v1} << shift_v1;

    // v2 layout: (c_size+1) * 1024
    assign c_size_v2 = {byte7[5:0], byte8, byte9};
    assign c_plus_v2 = {1'b0, c_size_v2} + 23'd1;

    // structure field picks the formula
    always_comb begin
        if (byte0[7:6] == 2'b00) begin
            o_blocks = {4'd0, bytes_v1[37:9]};
        end else begin
            o_blocks = {c_plus_v2, 10'd0};
        end
    end

endmodule

>>> rtl/core/sd_card_init_sequencer.sv
// sd card init sequencer: picks the next bring-up command from each outcome
//
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_ready   i_cmd .. i_switch_nibble
// out       from block o_out_valid / i_out_ready o_issue .. o_hs_mode
// cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_data (voltage window)
//
// each in beat is held in an input register, decided by one pass of
// logic and written to the result register: one beat per cycle while the
// results are taken. reset (synchronous, active low) clears the phase,
// the kept results and both valid flags. a full result register that is not
// taken holds the input register, which then drops o_in_ready.
module sd_card_init_sequencer
    import sdinit_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic               i_cmd_ok,
    input  logic [31:0]        i_rsp_word0,
    input  logic [31:0]        i_rsp_word1,
    input  logic [31:0]        i_rsp_word2,
    input  logic [31:0]        i_rsp_word3,
    input  logic [3:0]         i_switch_nibble,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_issue,
    output logic [5:0]         o_cmd_index,
    output logic [31:0]        o_cmd_arg,
    output logic [2:0]         o_rsp_kind,
    output logic               o_reads_data,
    output logic               o_done_res,
    output logic               o_failed,
    output logic               o_high_capacity,
    output logic [RCA_W-1:0]   o_card_address,
    output logic [CAP_W-1:0]   o_capacity_blocks,
    output logic               o_hs_mode
);

    // input register
    logic               r_in_valid;
    logic               r_cmd, r_cmd_ok;
    logic [127:0]       r_rsp;
    logic [3:0]         r_nibble;

    // sequencer state
    t_phase             r_phase, n_phase;
    logic               r_version_two, n_version_two;
    logic               r_hcs, n_hcs;
    logic [RCA_W-1:0]   r_rca, n_rca;
    logic [CAP_W-1:0]   r_size, n_size;
    logic               r_speed, n_speed;
    logic [23:0]        r_voltage_window;

    // decision of this pass
    logic               emit;
    logic               res_issue, res_rd, res_done, res_fail;
    logic [5:0]         res_idx;
    logic [31:0]        res_arg;
    logic [2:0]         res_kind;
    logic [31:0]        rca_arg;
    logic [CAP_W-1:0]   csd_blocks;
    logic               advance;

    // output register
    logic               r_out_valid;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign rca_arg     = {r_rca, 16'd0};

    // capacity from the csd words
    sdinit_capacity u_capacity (
        .i_csd    (r_rsp),
        .o_blocks (csd_blocks)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_cmd    <= i_cmd;
            r_cmd_ok <= i_cmd_ok;
            r_rsp    <= {i_rsp_word3, i_rsp_word2, i_rsp_word1, i_rsp_word0};
            r_nibble <= i_switch_nibble;
        end
    end

    // voltage window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_window <= VOLTAGE_RESET;
        end else if (i_cfg_valid) begin
            r_voltage_window <= i_cfg_data;
        end
    end

    // next command and state
    always_comb begin
        n_phase       = r_phase;
        n_version_two = r_version_two;
        n_hcs         = r_hcs;
        n_rca         = r_rca;
        n_size        = r_size;
        n_speed       = r_speed;
        emit          = 1'b1;
        res_issue     = 1'b0;
        res_idx       = CMD_GO_IDLE;
        res_arg       = 32'd0;
        res_kind      = RSP_NONE;
        res_rd        = 1'b0;
        res_done      = 1'b0;
        res_fail      = 1'b0;
        if (r_cmd == ITEM_START) begin
            // restart clears the kept results and resets the card
            n_version_two = 1'b0;
            n_hcs         = 1'b0;
            n_rca         = '0;
            n_size        = '0;
            n_speed       = 1'b0;
            n_phase       = PH_CMD0;
            res_issue     = 1'b1;
        end else if (r_phase == PH_IDLE || r_phase == PH_DONE || r_phase == PH_FAILED) begin
            emit = 1'b0;
        end else if (!r_cmd_ok && r_phase != PH_CMD8 && r_phase != PH_SWITCH) begin
            n_phase  = PH_FAILED;
            res_fail = 1'b1;
        end else begin
            unique case (r_phase)
                PH_CMD0: begin
                    n_phase   = PH_CMD8;
                    res_issue = 1'b1;
                    res_idx   = CMD_SEND_IF;
                    res_arg   = IF_COND_ARG;
                    res_kind  = RSP_R1;
                end
                PH_CMD8: begin
                    // failure here just means a v1 card
                    n_version_two = r_cmd_ok;
                    if (r_cmd_ok && r_rsp[31:0] != IF_COND_ARG) begin
                        n_phase  = PH_FAILED;
                        res_fail = 1'b1;
                    end else begin
                        n_phase   = PH_APP;
                        res_issue = 1'b1;
                        res_idx   = CMD_APP;
                        res_kind  = RSP_R1;
                    end
                end
                PH_APP: begin
                    n_phase   = PH_OPCOND;
                    res_issue = 1'b1;
                    res_idx   = ACMD_OP_COND;
                    res_arg   = {8'd0, r_voltage_window}
                              | (r_version_two ? HCS_ARG_BIT : 32'd0);
                    res_kind  = RSP_R3;
                end
                PH_OPCOND: begin
                    // loop until the card reports power-up done
                    res_issue = 1'b1;
                    if (r_rsp[31]) begin
                        n_hcs    = r_rsp[30];
                        n_phase  = PH_CID;
                        res_idx  = CMD_ALL_SEND_CID;
                        res_kind = RSP_R2;
                    end else begin
                        n_phase  = PH_APP;
                        res_idx  = CMD_APP;
                        res_kind = RSP_R1;
                    end
                end
                PH_CID: begin
                    n_phase   = PH_RCA;
                    res_issue = 1'b1;
                    res_idx   = CMD_SEND_RCA;
                    res_kind  = RSP_R1;
                end
                PH_RCA: begin
                    n_rca     = r_rsp[31:16];
                    n_phase   = PH_CSD;
                    res_issue = 1'b1;
                    res_idx   = CMD_SEND_CSD;
                    res_arg   = {r_rsp[31:16], 16'd0};
                    res_kind  = RSP_R2;
                end
                PH_CSD: begin
                    n_size    = csd_blocks;
                    n_phase   = PH_SELECT;
                    res_issue = 1'b1;
                    res_idx   = CMD_SELECT;
                    res_arg   = rca_arg;
                    res_kind  = RSP_R1B;
                end
                PH_SELECT: begin
                    n_phase   = PH_APP2;
                    res_issue = 1'b1;
                    res_idx   = CMD_APP;
                    res_arg   = rca_arg;
                    res_kind  = RSP_R1;
                end
                PH_APP2: begin
                    n_phase   = PH_WIDTH;
                    res_issue = 1'b1;
                    res_idx   = CMD_SWITCH;
                    res_arg   = BUS_WIDTH4_ARG;
                    res_kind  = RSP_R1B;
                end
                PH_WIDTH: begin
                    n_phase   = PH_SWITCH;
                    res_issue = 1'b1;
                    res_idx   = CMD_SWITCH;
                    res_arg   = SWITCH_HS_ARG;
                    res_kind  = RSP_R1;
                    res_rd    = 1'b1;
                end
                PH_SWITCH: begin
                    // a failed switch only leaves normal speed
                    n_speed  = r_cmd_ok && r_nibble == SWITCH_HS_OK;
                    n_phase  = PH_DONE;
                    res_done = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_version_two <= 1'b0;
            r_hcs         <= 1'b0;
            r_rca         <= '0;
            r_size        <= '0;
            r_speed       <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_version_two <= n_version_two;
            r_hcs         <= n_hcs;
            r_rca         <= n_rca;
            r_size        <= n_size;
            r_speed       <= n_speed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            o_issue           <= res_issue;
            o_cmd_index       <= res_idx;
            o_cmd_arg         <= res_arg;
            o_rsp_kind        <= res_kind;
            o_reads_data      <= res_rd;
            o_done_res        <= res_done;
            o_failed          <= res_fail;
            o_high_capacity   <= n_hcs;
            o_card_address    <= n_rca;
            o_capacity_blocks <= n_size;
            o_hs_mode         <= n_speed;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> tb/sdinit_checker.sv
// checker for the sd card init sequencer: predicts each result beat and compares it
`timescale 1ns / 100ps

module sdinit_checker
    import sdinit_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  logic               i_cmd_ok,
    input  logic [31:0]        i_rsp_word0,
    input  logic [31:0]        i_rsp_word1,
    input  logic [31:0]        i_rsp_word2,
    input  logic [31:0]        i_rsp_word3,
    input  logic [3:0]         i_switch_nibble,
    // configuration channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [23:0]        i_cfg_data,
    // result channel
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_issue,
    input  logic [5:0]         i_cmd_index,
    input  logic [31:0]        i_cmd_arg,
    input  logic [2:0]         i_rsp_kind,
    input  logic               i_reads_data,
    input  logic               i_done_res,
    input  logic               i_failed,
    input  logic               i_high_capacity,
    input  logic [RCA_W-1:0]   i_card_address,
    input  logic [CAP_W-1:0]   i_capacity_blocks,
    input  logic               i_hs_mode,
    // status to the top
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic               issue;
        logic [5:0]         index;
        logic [31:0]        arg;
        logic [2:0]         kind;
        logic               reads;
        logic               done;
        logic               failed;
        logic               high_cap;
        logic [RCA_W-1:0]   rca;
        logic [CAP_W-1:0]   blocks;
        logic               hs_mode;
    } t_sd_result;

    // OCR bit positions in the ACMD41 response
    localparam int OCR_BUSY = 31;
    localparam int OCR_CCS  = 30;

    // predicted card state
    t_phase             card_phase;
    logic [23:0]        window;
    logic               is_v2;
    logic               is_hc;
    logic [RCA_W-1:0]   rca;
    logic [CAP_W-1:0]   blocks;
    logic               is_hs;

    t_sd_result         result_q[$];
    int                 mismatches = 0;

    // card size in 512-byte blocks from the 128-bit csd
    function automatic logic [CAP_W-1:0] csd_blocks(input logic [127:0] csd);
        logic [7:0]  b0, b5, b6, b7, b8, b9, b10;
        logic [11:0] c_size;
        logic [2:0]  c_mult;
        logic [63:0] bytes;
        b0  = csd[119:112];
        b5  = csd[79:72];
        b6  = csd[71:64];
        b7  = csd[63:56];
        b8  = csd[55:48];
        b9  = csd[47:40];
        b10 = csd[39:32];
        // v1 layout: size, multiplier and block length give the byte count
        if (b0[7:6] == 2'b00) begin
            c_size = {b6[1:0], b7, b8[7:6]};
            c_mult = {b9[1:0], b10[7]};
            bytes  = (64'(c_size) + 64'd1) << (c_mult + 2 + b5[3:0]);
            return CAP_W'(bytes >> 9);
        end
        // v2 layout: size counts 512 kB units
        return CAP_W'((64'({b7[5:0], b8, b9}) + 64'd1) << 10);
    endfunction

    function automatic t_sd_result next_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                            input logic [2:0] kind);
        t_sd_result r;
        r       = '0;
        r.issue = 1'b1;
        r.index = idx;
        r.arg   = arg;
        r.kind  = kind;
        return r;
    endfunction

    // advance the card state by one input beat
    task automatic step_card(input logic kind, input logic ok, input logic [127:0] rsp,
                             input logic [3:0] nib, output bit emits, output t_sd_result res);
        logic [31:0] rca_arg;
        emits   = 1'b1;
        res     = '0;
        rca_arg = {rca, 16'h0000};
        if (kind == ITEM_START) begin
            is_v2      = 1'b0;
            is_hc      = 1'b0;
            rca        = '0;
            blocks     = '0;
            is_hs      = 1'b0;
            card_phase = PH_CMD0;
            res        = next_cmd(CMD_GO_IDLE, 32'h0, RSP_NONE);
        end else if (card_phase == PH_IDLE || card_phase == PH_DONE ||
                     card_phase == PH_FAILED) begin
            emits = 1'b0;
        end else if (!ok && card_phase != PH_CMD8 && card_phase != PH_SWITCH) begin
            card_phase = PH_FAILED;
            res.failed = 1'b1;
        end else begin
            case (card_phase)
                PH_CMD0: begin
                    card_phase = PH_CMD8;
                    res = next_cmd(CMD_SEND_IF, IF_COND_ARG, RSP_R1);
                end
                PH_CMD8: begin
                    // no answer to cmd8 means a v1 card; a wrong echo is fatal
                    is_v2 = ok;
                    if (ok && rsp[31:0] != IF_COND_ARG) begin
                        card_phase = PH_FAILED;
                        res.failed = 1'b1;
                    end else begin
                        card_phase = PH_APP;
                        res = next_cmd(CMD_APP, 32'h0, RSP_R1);
                    end
                end
                PH_APP: begin
                    card_phase = PH_OPCOND;
                    res = next_cmd(ACMD_OP_COND, {8'h00, window} | (is_v2 ? HCS_ARG_BIT : 32'h0),
                                   RSP_R3);
                end
                PH_OPCOND: begin
                    // poll until the card reports power-up done
                    if (rsp[OCR_BUSY]) begin
                        is_hc      = rsp[OCR_CCS];
                        card_phase = PH_CID;
                        res = next_cmd(CMD_ALL_SEND_CID, 32'h0, RSP_R2);
                    end else begin
                        card_phase = PH_APP;
                        res = next_cmd(CMD_APP, 32'h0, RSP_R1);
                    end
                end
                PH_CID: begin
                    card_phase = PH_RCA;
                    res = next_cmd(CMD_SEND_RCA, 32'h0, RSP_R1);
                end
                PH_RCA: begin
                    rca        = rsp[31:16];
                    card_phase = PH_CSD;
                    res = next_cmd(CMD_SEND_CSD, {rsp[31:16], 16'h0000}, RSP_R2);
                end
                PH_CSD: begin
                    blocks     = csd_blocks(rsp);
                    card_phase = PH_SELECT;
                    res = next_cmd(CMD_SELECT, rca_arg, RSP_R1B);
                end
                PH_SELECT: begin
                    card_phase = PH_APP2;
                    res = next_cmd(CMD_APP, rca_arg, RSP_R1);
                end
                PH_APP2: begin
                    // acmd6 shares index 6 with the switch command
                    card_phase = PH_WIDTH;
                    res = next_cmd(CMD_SWITCH, BUS_WIDTH4_ARG, RSP_R1B);
                end
                PH_WIDTH: begin
                    card_phase = PH_SWITCH;
                    res = next_cmd(CMD_SWITCH, SWITCH_HS_ARG, RSP_R1);
                    res.reads = 1'b1;
                end
                default: begin
                    // switch outcome: a failed cmd6 just leaves normal speed
                    is_hs      = ok && nib == SWITCH_HS_OK;
                    card_phase = PH_DONE;
                    res.done   = 1'b1;
                end
            endcase
        end
        res.high_cap = is_hc;
        res.rca      = rca;
        res.blocks   = blocks;
        res.hs_mode  = is_hs;
    endtask

    task automatic check_field(input string name, input logic [CAP_W-1:0] want,
                               input logic [CAP_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        bit         emits;
        t_sd_result res;
        t_sd_result want;
        if (!i_rst_n) begin
            card_phase = PH_IDLE;
            window     = VOLTAGE_RESET;
            is_v2      = 1'b0;
            is_hc      = 1'b0;
            rca        = '0;
            blocks     = '0;
            is_hs      = 1'b0;
            result_q.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing predicted");
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("issue", want.issue, i_issue);
                    check_field("cmd_index", want.index, i_cmd_index);
                    check_field("cmd_arg", want.arg, i_cmd_arg);
                    check_field("rsp_kind", want.kind, i_rsp_kind);
                    check_field("reads_data", want.reads, i_reads_data);
                    check_field("done_res", want.done, i_done_res);
                    check_field("failed", want.failed, i_failed);
                    check_field("high_capacity", want.high_cap, i_high_capacity);
                    check_field("card_address", want.rca, i_card_address);
                    check_field("capacity_blocks", want.blocks, i_capacity_blocks);
                    check_field("hs_mode", want.hs_mode, i_hs_mode);
                end
            end
            // voltage window write
            if (i_cfg_valid && i_cfg_ready)
                window = i_cfg_data;
            // input beat
            if (i_in_valid && i_in_ready) begin
                step_card(i_cmd, i_cmd_ok, {i_rsp_word3, i_rsp_word2, i_rsp_word1, i_rsp_word0},
                          i_switch_nibble, emits, res);
                if (emits)
                    result_q.push_back(res);
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/testbench.sv
// top of the sd card init sequencer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import sdinit_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 1850;
    localparam int PHASE_ITEMS = 300;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               cmd          = ITEM_START;
    logic               cmd_ok       = 1'b0;
    logic [31:0]        rsp_word0    = '0;
    logic [31:0]        rsp_word1    = '0;
    logic [31:0]        rsp_word2    = '0;
    logic [31:0]        rsp_word3    = '0;
    logic [3:0]         switch_nib   = '0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_data     = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               issue;
    logic [5:0]         cmd_index;
    logic [31:0]        cmd_arg;
    logic [2:0]         rsp_kind;
    logic               reads_data;
    logic               done_res;
    logic               failed;
    logic               high_capacity;
    logic [RCA_W-1:0]   card_address;
    logic [CAP_W-1:0]   capacity_blocks;
    logic               hs_mode;

    int                 fail_count;
    int                 pending;
    int                 items_sent   = 0;
    int                 idle_pct     = 20;
    int                 stall_pct    = 20;
    int                 quiet        = 0;

    always #4 clk = ~clk;

    sd_card_init_sequencer u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_cmd             (cmd),
        .i_cmd_ok          (cmd_ok),
        .i_rsp_word0       (rsp_word0),
        .i_rsp_word1       (rsp_word1),
        .i_rsp_word2       (rsp_word2),
        .i_rsp_word3       (rsp_word3),
        .i_switch_nibble   (switch_nib),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_issue           (issue),
        .o_cmd_index       (cmd_index),
        .o_cmd_arg         (cmd_arg),
        .o_rsp_kind        (rsp_kind),
        .o_reads_data      (reads_data),
        .o_done_res        (done_res),
        .o_failed          (failed),
        .o_high_capacity   (high_capacity),
        .o_card_address    (card_address),
        .o_capacity_blocks (capacity_blocks),
        .o_hs_mode         (hs_mode)
    );

    sdinit_checker u_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_cmd             (cmd),
        .i_cmd_ok          (cmd_ok),
        .i_rsp_word0       (rsp_word0),
        .i_rsp_word1       (rsp_word1),
        .i_rsp_word2       (rsp_word2),
        .i_rsp_word3       (rsp_word3),
        .i_switch_nibble   (switch_nib),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_issue           (issue),
        .i_cmd_index       (cmd_index),
        .i_cmd_arg         (cmd_arg),
        .i_rsp_kind        (rsp_kind),
        .i_reads_data      (reads_data),
        .i_done_res        (done_res),
        .i_failed          (failed),
        .i_high_capacity   (high_capacity),
        .i_card_address    (card_address),
        .i_capacity_blocks (capacity_blocks),
        .i_hs_mode         (hs_mode),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // result side back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // watchdog: too long without any beat ends the run
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // one input beat; valid stays high afterwards until the next beat or a drain
    task automatic put_item(input logic kind, input logic ok,
                            input logic [31:0] w0, w1, w2, w3,
                            input logic [3:0] nib, input bit counted);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= kind;
        cmd_ok     <= ok;
        rsp_word0  <= w0;
        rsp_word1  <= w1;
        rsp_word2  <= w2;
        rsp_word3  <= w3;
        switch_nib <= nib;
        do @(posedge clk); while (!in_ready);
        if (counted)
            items_sent++;
    endtask

    task automatic answer(input logic ok, input logic [31:0] w0);
        put_item(ITEM_OUTCOME, ok, w0, $urandom, $urandom, $urandom, 4'($urandom), 1'b1);
    endtask

    task automatic begin_card();
        put_item(ITEM_START, 1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                 4'($urandom), 1'b1);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one bring-up attempt with random responses, cut short now and then
    task automatic run_card();
        int unsigned stop_at;
        logic        fail_mode;
        int unsigned polls;
        int unsigned pick;
        logic [31:0] csd_top;
        stop_at   = ($urandom_range(3) == 0) ? $urandom_range(1, 11) : 0;
        fail_mode = 1'($urandom_range(1));
        polls     = ($urandom_range(7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        csd_top   = $urandom;
        // about half the cards carry a v1 csd
        if ($urandom_range(1))
            csd_top[23:22] = 2'b00;
        begin_card();
        for (int s = 1; s <= 11; s++) begin
            // a command error, or a host restart with the next start
            if (s == stop_at) begin
                if (fail_mode)
                    answer(1'b0, $urandom);
                return;
            end
            case (s)
                2: begin
                    pick = $urandom_range(19);
                    if (pick < 10) begin
                        answer(1'b1, IF_COND_ARG);
                    end else if (pick < 17) begin
                        answer(1'b0, $urandom);
                    end else begin
                        answer(1'b1, IF_COND_ARG ^ (32'd1 << $urandom_range(31)));
                        return;
                    end
                end
                3: begin
                    repeat (polls) begin
                        answer(1'b1, $urandom);
                        answer(1'b1, {1'b0, 31'($urandom)});
                    end
                    answer(1'b1, $urandom);
                end
                4: answer(1'b1, {1'b1, 31'($urandom)});
                7: put_item(ITEM_OUTCOME, 1'b1, $urandom, $urandom, $urandom, csd_top,
                            4'($urandom), 1'b1);
                11: put_item(ITEM_OUTCOME, $urandom_range(3) != 0, $urandom, $urandom,
                             $urandom, $urandom,
                             $urandom_range(1) ? SWITCH_HS_OK : 4'($urandom), 1'b1);
                default: answer(1'b1, $urandom);
            endcase
        end
        // outcomes after the end are ignored by the block
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                put_item(ITEM_OUTCOME, 1'($urandom_range(1)), $urandom, $urandom, $urandom,
                         $urandom, 4'($urandom), 1'b0);
    endtask

    initial begin
        int phase_no;
        int phase_end;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_window(24'hFF_FFFF);

        // outcome before any start is ignored
        put_item(ITEM_OUTCOME, 1'b1, '1, '1, '1, '1, 4'hF, 1'b1);
        // full v2 high-capacity bring-up with one busy poll and largest csd
        begin_card();
        answer(1'b1, 32'h0);
        answer(1'b1, IF_COND_ARG);
        answer(1'b1, '1);
        answer(1'b1, 32'h7FFF_FFFF);
        answer(1'b1, 32'h0);
        answer(1'b1, 32'hC000_0000);
        put_item(ITEM_OUTCOME, 1'b1, '1, '1, '1, '1, 4'hF, 1'b1);
        answer(1'b1, 32'hFFFF_0000);
        put_item(ITEM_OUTCOME, 1'b1, '1, '1, '1, '1, 4'hF, 1'b1);
        answer(1'b1, 32'h0);
        answer(1'b1, 32'h0);
        answer(1'b1, 32'h0);
        put_item(ITEM_OUTCOME, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, SWITCH_HS_OK, 1'b1);
        // outcome after done is ignored
        put_item(ITEM_OUTCOME, 1'b0, '0, '0, '0, '0, 4'h0, 1'b1);
        // cmd8 echo mismatch
        begin_card();
        answer(1'b1, 32'h0);
        answer(1'b1, 32'h0000_01AB);
        // v1 card, then a failed acmd41
        begin_card();
        answer(1'b1, 32'h0);
        answer(1'b0, '1);
        answer(1'b1, '1);
        answer(1'b0, '1);
        drain();

        // random phases, each under its own voltage window
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase_no)
                0:       write_window(24'h00_0000);
                1:       write_window(VOLTAGE_RESET);
                3:       write_window(24'hFF_FFFF);
                default: write_window(24'($urandom));
            endcase
            // one phase runs with no idling on either side
            idle_pct  = (phase_no == 2) ? 0 : 20;
            stall_pct = (phase_no == 2) ? 0 : 20;
            phase_end = items_sent + PHASE_ITEMS;
            if (phase_end > ITEM_TARGET)
                phase_end = ITEM_TARGET;
            while (items_sent < phase_end) begin
                run_card();
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 5))
                        put_item($urandom_range(3) != 0 ? ITEM_OUTCOME : ITEM_START,
                                 1'($urandom_range(1)), $urandom, $urandom, $urandom,
                                 $urandom, 4'($urandom), 1'b1);
            end
            drain();
            phase_no++;
        end

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
